// ===== rtl/stt_pkg.sv =====
// Package for the session ticket table: transfer structs, action and status codes,
// controller/datapath command and status structs, id mask helper. No dependencies.
`timescale 1ns / 1ps
package stt_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int ID_BYTES_DEF   = 16;

  localparam logic [2:0] ACT_STAGE      = 3'd0;
  localparam logic [2:0] ACT_INSERT     = 3'd1;
  localparam logic [2:0] ACT_LOOKUP     = 3'd2;
  localparam logic [2:0] ACT_CONSUME    = 3'd3;
  localparam logic [2:0] ACT_INVALIDATE = 3'd4;
  localparam logic [2:0] ACT_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EXPIRED  = 2'd3;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [4:0]  id_length;
    logic [63:0] psk_word;
    logic [2:0]  position;
    logic [31:0] age_add;
    logic [31:0] lifetime_seconds;
    logic [63:0] time_ms;
    logic [31:0] max_early;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot_index;
    logic [63:0] psk_out;
    logic [1:0]  word_number;
    logic [31:0] age_add_out;
    logic [31:0] lifetime_out;
    logic [63:0] issued_out;
    logic [31:0] max_early_out;
    logic        used_flag;
    logic        early_data_ok;
    logic        last;
  } out_t;

  typedef struct packed {
    logic load;
    logic simple;
    logic scan;
    logic mul;
    logic cmp;
    logic wr;
    logic hit_first;
    logic hit_out;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic is_insert;
    logic scan_end;
    logic cand;
    logic expired;
    logic wc_last;
  } sts_t;

  // mask of the top n bytes of a word, n of 8 or more gives all ones
  function automatic logic [63:0] top_bytes(input logic [4:0] n);
    logic [6:0] sh;
    sh = 7'd64 - {1'b0, n[2:0], 3'b000};
    if (n == 5'd0) return 64'd0;
    if (n >= 5'd8) return ~64'd0;
    return ~64'd0 << sh;
  endfunction

endpackage

// ===== rtl/stt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module stt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/stt_ctrl.sv =====
// Controller state machine of the session ticket table.
// Depends on stt_pkg (cmd_t, sts_t).
`timescale 1ns / 1ps
module stt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  stt_pkg::sts_t sts,
  output logic          busy,
  output stt_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_MUL    = 9'b000001000,
    S_CMP    = 9'b000010000,
    S_WR     = 9'b000100000,
    S_HRD    = 9'b001000000,
    S_HOUT   = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (sts.need_scan) begin
          state_next = S_SCAN;
        end else begin
          cmd.simple = 1'b1;
          state_next = S_RESP;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          if (sts.is_insert) state_next = S_WR;
          else if (sts.cand) state_next = S_MUL;
          else state_next = S_RESP;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        state_next = sts.expired ? S_RESP : S_HRD;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (sts.wc_last) state_next = S_RESP;
      end
      S_HRD: begin
        cmd.hit_first = 1'b1;
        state_next = S_HOUT;
      end
      S_HOUT: begin
        cmd.hit_out = 1'b1;
        if (sts.wc_last) state_next = S_IDLE;
      end
      S_RESP: begin
        cmd.resp = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/stt_datapath.sv =====
// Datapath of the session ticket table: slot registers, scan unit, expiry check, PSK RAM.
// Depends on stt_pkg and stt_ram.
`timescale 1ns / 1ps
module stt_datapath #(
  parameter int SLOT_COUNT = stt_pkg::SLOT_COUNT_DEF,
  parameter int ID_BYTES   = stt_pkg::ID_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  stt_pkg::in_t  request,
  input  stt_pkg::cmd_t cmd,
  output stt_pkg::sts_t sts,
  output stt_pkg::out_t result,
  output logic          result_valid
);

  localparam int IW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PD  = SLOT_COUNT * 4;
  localparam int PAW = $clog2(PD);

  stt_pkg::in_t req;
  logic [63:0]  hi, lo;

  logic          valid  [SLOT_COUNT];
  logic          used   [SLOT_COUNT];
  logic [4:0]    idlen  [SLOT_COUNT];
  logic [63:0]   idh    [SLOT_COUNT];
  logic [63:0]   idl    [SLOT_COUNT];
  logic [31:0]   age    [SLOT_COUNT];
  logic [31:0]   life   [SLOT_COUNT];
  logic [63:0]   issued [SLOT_COUNT];
  logic [31:0]   early  [SLOT_COUNT];
  logic [63:0]   stage  [4];

  logic [IW-1:0] cnt, found_idx, best_idx, tgt, pidx;
  logic          found;
  logic [63:0]   best_issued;
  logic [1:0]    wc;
  logic [63:0]   prod;
  logic [1:0]    res_status;
  logic [2:0]    res_slot;

  logic          len_bad, match_now, cand_now, pos_bad;
  logic [63:0]   expiry;
  logic          ram_we;
  logic [PAW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_rdata;
  logic [1:0]    rd_word;

  assign len_bad = (req.id_length == 5'd0) || (req.id_length > 5'(ID_BYTES));
  assign pos_bad = (32'(req.position) >= SLOT_COUNT);
  assign pidx    = IW'(req.position);
  assign tgt     = found ? found_idx : best_idx;

  assign match_now = valid[cnt] && (idlen[cnt] == req.id_length) &&
                     (idh[cnt] == hi) && (idl[cnt] == lo);
  assign cand_now  = match_now || ((req.action == stt_pkg::ACT_INSERT) && !valid[cnt]);
  assign expiry    = issued[tgt] + prod;

  always_comb begin
    sts.need_scan = ((req.action == stt_pkg::ACT_INSERT) ||
                     (req.action == stt_pkg::ACT_LOOKUP)) && !len_bad;
    sts.is_insert = (req.action == stt_pkg::ACT_INSERT);
    sts.scan_end  = cand_now || (cnt == IW'(SLOT_COUNT - 1));
    sts.cand      = cand_now;
    sts.expired   = (expiry < req.time_ms);
    sts.wc_last   = (wc == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        valid[i] <= 1'b0; used[i] <= 1'b0; idlen[i] <= '0;
        idh[i] <= '0; idl[i] <= '0; age[i] <= '0; life[i] <= '0;
        issued[i] <= '0; early[i] <= '0;
      end
      for (int k = 0; k < 4; k++) stage[k] <= '0;
      found <= 1'b0;
      cnt   <= '0;
      wc    <= '0;
    end else begin
      if (cmd.load) begin
        req   <= request;
        hi    <= request.id_high & stt_pkg::top_bytes(request.id_length);
        lo    <= request.id_low & ((request.id_length > 5'd8) ?
                 stt_pkg::top_bytes(request.id_length - 5'd8) : 64'd0);
        cnt   <= '0;
        found <= 1'b0;
        wc    <= '0;
      end
      if (cmd.simple) begin
        unique case (req.action)
          stt_pkg::ACT_STAGE: begin
            res_slot <= 3'd0;
            if (!req.position[2]) begin
              stage[req.position[1:0]] <= req.psk_word;
              res_status <= stt_pkg::ST_OK;
            end else begin
              res_status <= stt_pkg::ST_REJECT;
            end
          end
          stt_pkg::ACT_CONSUME: begin
            res_slot <= req.position;
            if (!pos_bad && valid[pidx] && !used[pidx]) begin
              used[pidx] <= 1'b1;
              res_status <= stt_pkg::ST_OK;
            end else begin
              res_status <= stt_pkg::ST_REJECT;
            end
          end
          stt_pkg::ACT_INVALIDATE: begin
            res_slot <= req.position;
            if (!pos_bad) begin
              valid[pidx] <= 1'b0; used[pidx] <= 1'b0; idlen[pidx] <= '0;
              idh[pidx] <= '0; idl[pidx] <= '0; age[pidx] <= '0; life[pidx] <= '0;
              issued[pidx] <= '0; early[pidx] <= '0;
              res_status <= stt_pkg::ST_OK;
            end else begin
              res_status <= stt_pkg::ST_REJECT;
            end
          end
          stt_pkg::ACT_CLEAR: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              valid[i] <= 1'b0; used[i] <= 1'b0; idlen[i] <= '0;
              idh[i] <= '0; idl[i] <= '0; age[i] <= '0; life[i] <= '0;
              issued[i] <= '0; early[i] <= '0;
            end
            res_status <= stt_pkg::ST_OK;
            res_slot   <= 3'd0;
          end
          default: begin
            res_status <= stt_pkg::ST_REJECT;
            res_slot   <= 3'd0;
          end
        endcase
      end
      if (cmd.scan) begin
        // one slot a cycle: first candidate, and the oldest slot for eviction
        if (!found && cand_now) begin
          found     <= 1'b1;
          found_idx <= cnt;
        end
        if ((cnt == '0) || (issued[cnt] < best_issued)) begin
          best_idx    <= cnt;
          best_issued <= issued[cnt];
        end
        cnt <= cnt + 1'b1;
        res_status <= stt_pkg::ST_NOTFOUND;
        res_slot   <= 3'd0;
      end
      if (cmd.mul) begin
        prod <= {22'd0, 42'(life[tgt]) * 42'(stt_pkg::MS_PER_S)};
      end
      if (cmd.cmp && sts.expired) begin
        valid[tgt] <= 1'b0; used[tgt] <= 1'b0; idlen[tgt] <= '0;
        idh[tgt] <= '0; idl[tgt] <= '0; age[tgt] <= '0; life[tgt] <= '0;
        issued[tgt] <= '0; early[tgt] <= '0;
        res_status <= stt_pkg::ST_EXPIRED;
        res_slot   <= 3'(tgt);
      end
      if (cmd.wr) begin
        if (wc == 2'd0) begin
          valid[tgt] <= 1'b1; used[tgt] <= 1'b0; idlen[tgt] <= req.id_length;
          idh[tgt] <= hi; idl[tgt] <= lo; age[tgt] <= req.age_add;
          life[tgt] <= req.lifetime_seconds; issued[tgt] <= req.time_ms;
          early[tgt] <= req.max_early;
        end
        wc <= wc + 2'd1;
        res_status <= stt_pkg::ST_OK;
        res_slot   <= 3'(tgt);
      end
      if (cmd.hit_first) wc <= 2'd0;
      if (cmd.hit_out) wc <= wc + 2'd1;
    end
  end

  assign rd_word   = cmd.hit_first ? 2'd0 : (wc + 2'd1);
  assign ram_we    = cmd.wr;
  assign ram_waddr = PAW'({tgt, wc});
  assign ram_raddr = PAW'({tgt, rd_word});

  stt_ram #(.WIDTH(64), .DEPTH(PD)) u_psk (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (stage[wc]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    result = '0;
    result.last = 1'b1;
    if (cmd.hit_out) begin
      result.status        = stt_pkg::ST_OK;
      result.slot_index    = 3'(tgt);
      result.psk_out       = ram_rdata;
      result.word_number   = wc;
      result.age_add_out   = age[tgt];
      result.lifetime_out  = life[tgt];
      result.issued_out    = issued[tgt];
      result.max_early_out = early[tgt];
      result.used_flag     = used[tgt];
      result.early_data_ok = !used[tgt] && (early[tgt] != 32'd0);
      result.last          = (wc == 2'd3);
    end else begin
      result.status     = res_status;
      result.slot_index = res_slot;
    end
  end

  assign result_valid = cmd.resp || cmd.hit_out;

endmodule

// ===== rtl/session_ticket_table.sv =====
// Session ticket table: one command per transfer, results strobed for one cycle each.
// Stage/consume/invalidate/clear: a single status result. Insert: a scan (one slot a cycle)
// plus 4 PSK RAM writes. Lookup: scan, multiply and expiry compare, then 4 words on
// consecutive cycles from the PSK RAM read port, or a single not-found or expired status.
// busy is high from the transfer until the last result; the receiver cannot stall.
// Synchronous reset empties every slot and zeroes the staged PSK.
`timescale 1ns / 1ps
module session_ticket_table #(
  parameter int SLOT_COUNT = stt_pkg::SLOT_COUNT_DEF,
  parameter int ID_BYTES   = stt_pkg::ID_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  stt_pkg::in_t  request,
  output stt_pkg::out_t result,
  output logic          result_valid
);

  stt_pkg::cmd_t cmd;
  stt_pkg::sts_t sts;

  stt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  stt_datapath #(.SLOT_COUNT(SLOT_COUNT), .ID_BYTES(ID_BYTES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result strobe while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("no busy after transfer");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !busy) else $error("busy after last result");

  a_words_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |=> result_valid)
    else $error("gap in hit results");

endmodule

// ===== tb/sv/ticket_checker.sv =====
// Checker for the session ticket table: watches accepted commands and strobed results,
// keeps its own copy of the table and compares each result field. Depends on stt_pkg.
`timescale 1ns / 1ps
module ticket_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  stt_pkg::in_t  request,
  input  stt_pkg::out_t result,
  input  logic          result_valid,
  output int            fail_count,
  output int            pending
);
  import stt_pkg::*;

  localparam int NSLOT = 8;

  logic        t_valid [NSLOT];
  logic        t_used  [NSLOT];
  logic [4:0]  t_len   [NSLOT];
  logic [63:0] t_hi    [NSLOT];
  logic [63:0] t_lo    [NSLOT];
  logic [63:0] t_psk   [NSLOT][4];
  logic [31:0] t_age   [NSLOT];
  logic [31:0] t_life  [NSLOT];
  logic [63:0] t_iss   [NSLOT];
  logic [31:0] t_early [NSLOT];
  logic [63:0] staged  [4];

  out_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [63:0] byte_mask(input int n);
    if (n <= 0) return 64'd0;
    if (n >= 8) return ~64'd0;
    return ~64'd0 << (64 - 8 * n);
  endfunction

  task automatic wipe(input int i);
    t_valid[i] = 0; t_used[i] = 0; t_len[i] = 0; t_hi[i] = 0; t_lo[i] = 0;
    for (int k = 0; k < 4; k++) t_psk[i][k] = 0;
    t_age[i] = 0; t_life[i] = 0; t_iss[i] = 0; t_early[i] = 0;
  endtask

  task automatic push(input logic [1:0] st, input logic [2:0] slot);
    out_t r;
    r = '0;
    r.status = st; r.slot_index = slot; r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  task automatic apply_command(input in_t q);
    logic [63:0] hi, lo, expiry;
    int          v;
    bit          found;
    out_t        r;
    case (q.action)
      ACT_STAGE: begin
        if (q.position < 4) begin
          staged[q.position[1:0]] = q.psk_word; push(ST_OK, 0);
        end else push(ST_REJECT, 0);
      end
      ACT_INSERT, ACT_LOOKUP: begin
        if (q.id_length == 0 || q.id_length > 16) begin
          push(ST_REJECT, 0);
          return;
        end
        hi = q.id_high & byte_mask(q.id_length);
        lo = q.id_low & byte_mask(int'(q.id_length) - 8);
        found = 0; v = 0;
        if (q.action == ACT_INSERT) begin
          for (int i = 0; i < NSLOT && !found; i++)
            if (!t_valid[i] || (t_len[i] == q.id_length && t_hi[i] == hi && t_lo[i] == lo)) begin
              v = i; found = 1;
            end
          if (!found)
            for (int i = 1; i < NSLOT; i++) if (t_iss[i] < t_iss[v]) v = i;
          wipe(v);
          t_hi[v] = hi; t_lo[v] = lo; t_len[v] = q.id_length;
          for (int k = 0; k < 4; k++) t_psk[v][k] = staged[k];
          t_age[v] = q.age_add; t_life[v] = q.lifetime_seconds;
          t_iss[v] = q.time_ms; t_early[v] = q.max_early; t_valid[v] = 1;
          push(ST_OK, v[2:0]);
          return;
        end
        for (int i = 0; i < NSLOT; i++) begin
          if (!(t_valid[i] && t_len[i] == q.id_length && t_hi[i] == hi && t_lo[i] == lo))
            continue;
          expiry = t_iss[i] + 64'(t_life[i]) * 64'd1000;
          if (expiry < q.time_ms) begin
            wipe(i); push(ST_EXPIRED, i[2:0]);
            return;
          end
          for (int k = 0; k < 4; k++) begin
            r = '0;
            r.status = ST_OK; r.slot_index = i[2:0]; r.psk_out = t_psk[i][k];
            r.word_number = k[1:0]; r.age_add_out = t_age[i]; r.lifetime_out = t_life[i];
            r.issued_out = t_iss[i]; r.max_early_out = t_early[i]; r.used_flag = t_used[i];
            r.early_data_ok = !t_used[i] && t_early[i] != 0; r.last = (k == 3);
            expected_results.push_back(r);
          end
          return;
        end
        push(ST_NOTFOUND, 0);
      end
      ACT_CONSUME: begin
        if (!t_valid[q.position] || t_used[q.position]) push(ST_REJECT, q.position);
        else begin
          t_used[q.position] = 1; push(ST_OK, q.position);
        end
      end
      ACT_INVALIDATE: begin
        wipe(q.position); push(ST_OK, q.position);
      end
      ACT_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) wipe(i);
        push(ST_OK, 0);
      end
      default: push(ST_REJECT, 0);
    endcase
  endtask

  // a result strobed in the same cycle as a new command belongs to an older one,
  // so compare first and predict after
  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      for (int i = 0; i < NSLOT; i++) wipe(i);
      for (int k = 0; k < 4; k++) staged[k] = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (result_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %p", result);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (e.status !== result.status) begin
            $error("status exp %0d got %0d", e.status, result.status); fail_count++; end
          if (e.slot_index !== result.slot_index) begin
            $error("slot_index exp %0d got %0d", e.slot_index, result.slot_index); fail_count++; end
          if (e.psk_out !== result.psk_out) begin
            $error("psk_out exp %h got %h", e.psk_out, result.psk_out); fail_count++; end
          if (e.word_number !== result.word_number) begin
            $error("word_number exp %0d got %0d", e.word_number, result.word_number);
            fail_count++;
          end
          if (e.age_add_out !== result.age_add_out) begin
            $error("age_add_out exp %h got %h", e.age_add_out, result.age_add_out);
            fail_count++;
          end
          if (e.lifetime_out !== result.lifetime_out) begin
            $error("lifetime_out exp %h got %h", e.lifetime_out, result.lifetime_out);
            fail_count++;
          end
          if (e.issued_out !== result.issued_out) begin
            $error("issued_out exp %h got %h", e.issued_out, result.issued_out); fail_count++; end
          if (e.max_early_out !== result.max_early_out) begin
            $error("max_early_out exp %h got %h", e.max_early_out, result.max_early_out);
            fail_count++;
          end
          if (e.used_flag !== result.used_flag) begin
            $error("used_flag exp %b got %b", e.used_flag, result.used_flag); fail_count++; end
          if (e.early_data_ok !== result.early_data_ok) begin
            $error("early_data_ok exp %b got %b", e.early_data_ok, result.early_data_ok);
            fail_count++;
          end
          if (e.last !== result.last) begin
            $error("last exp %b got %b", e.last, result.last); fail_count++; end
        end
      end
      if (start && !busy) apply_command(request);
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the session ticket table testbench: clock, reset, command stimulus and verdict.
// Depends on stt_pkg, session_ticket_table and ticket_checker.
`timescale 1ns / 1ps
module tb_top;
  import stt_pkg::*;

  logic  clk = 0;
  logic  rst = 1;
  logic  start = 0;
  logic  busy;
  in_t   request = '0;
  out_t  result;
  logic  result_valid;
  int    fail_count, pending;
  int    cycles = 0;

  // small pool of ids so that lookups hit, inserts collide and eviction happens
  logic [63:0] pool_hi [4];
  logic [63:0] pool_lo [4];
  logic [4:0]  pool_len[4];
  logic [63:0] clock_ms = 64'd1000;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  session_ticket_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .result(result), .result_valid(result_valid)
  );

  ticket_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .result(result), .result_valid(result_valid),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // one transfer: drive at the falling edge, hold until accepted
  task automatic send(input in_t q);
    request <= q;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic in_t random_fields();
    in_t q;
    q = '0;
    q.id_high = rand64(); q.id_low = rand64(); q.psk_word = rand64();
    q.id_length = 5'($urandom_range(0, 31)); q.position = 3'($urandom());
    q.age_add = $urandom(); q.lifetime_seconds = $urandom(); q.time_ms = rand64();
    q.max_early = $urandom(); q.action = 3'($urandom());
    return q;
  endfunction

  function automatic in_t pooled(input logic [2:0] act);
    in_t q;
    int  p;
    q = random_fields();
    p = $urandom_range(0, 3);
    q.action = act;
    q.id_high = pool_hi[p] | (rand64() & ~top_bytes(pool_len[p]));
    q.id_low = pool_lo[p];
    q.id_length = pool_len[p];
    q.lifetime_seconds = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 2)) :
                         32'($urandom_range(1, 100));
    q.time_ms = clock_ms;
    q.max_early = $urandom_range(0, 2) == 0 ? 32'd0 : $urandom();
    return q;
  endfunction

  initial begin
    in_t q;
    int  burst;
    for (int p = 0; p < 4; p++) begin
      pool_len[p] = 5'($urandom_range(1, 16));
      pool_hi[p] = rand64() & top_bytes(pool_len[p]);
      pool_lo[p] = pool_len[p] > 5'd8 ? rand64() & top_bytes(pool_len[p] - 5'd8) : 64'd0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: staging, bad lengths, fill and evict, expiry, consume twice, invalidate twice, codes 6/7, clear
    for (int k = 0; k < 5; k++) begin
      q = '0; q.action = ACT_STAGE; q.position = 3'(k); q.psk_word = k[0] ? ~64'd0 : rand64();
      send(q);
    end
    q = '0; q.action = ACT_INSERT; q.id_length = 0; send(q);
    q.id_length = 5'd17; send(q);
    q.action = ACT_LOOKUP; q.id_length = 5'd31; send(q);
    for (int i = 0; i < 9; i++) begin
      q = '0; q.action = ACT_INSERT; q.id_length = 5'(i + 8); q.id_high = ~64'd0;
      q.id_low = ~64'd0; q.time_ms = i == 8 ? 64'd5 : ~64'd0 - 64'(i);
      q.lifetime_seconds = ~32'd0; q.max_early = i[0] ? ~32'd0 : 32'd0;
      q.age_add = ~32'd0; send(q);
    end
    q.action = ACT_LOOKUP; q.id_length = 5'd16; q.time_ms = ~64'd0; send(q);
    q.id_length = 5'd15; send(q);
    q.action = ACT_CONSUME; q.position = 3'd7; send(q); send(q);
    q.action = ACT_LOOKUP; q.id_length = 5'd15; q.time_ms = 0; send(q);
    q.action = ACT_INVALIDATE; q.position = 3'd0; send(q); send(q);
    q.action = ACT_CONSUME; send(q);
    q.action = 3'd6; send(q);
    q.action = 3'd7; send(q);
    q.action = ACT_CLEAR; send(q);

    // random: pooled inserts and lookups, random staging, consume, invalidate and clear, some raw noise
    for (int n = 0; n < 150; ) begin
      burst = $urandom_range(1, 8);
      for (int b = 0; b < burst; b++, n++) begin
        clock_ms = clock_ms + 64'($urandom_range(0, 40000));
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            q = random_fields(); q.action = ACT_STAGE; q.position = 3'($urandom_range(0, 4));
          end
          3, 4, 5, 6: q = pooled(ACT_INSERT);
          7, 8, 9, 10, 11: q = pooled(ACT_LOOKUP);
          12, 13: begin
            q = random_fields(); q.action = ACT_CONSUME;
          end
          14: begin
            q = random_fields(); q.action = ACT_INVALIDATE;
          end
          15: begin
            q = random_fields(); q.action = $urandom_range(0, 9) == 0 ? ACT_CLEAR : ACT_LOOKUP;
          end
          default: q = random_fields();
        endcase
        send(q);
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 12));
    end
    start <= 1'b0;

    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
